[rtl/core/smf_pkg.sv]
package smf_pkg;

  // Width and reset value of the window length register
  localparam int WL_BITS  = 4;
  localparam int WL_RESET = 5;

  // Per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic shift;  // move samples one cell down the chain, reload probes
    logic rank;   // compare against the probe and rotate probes
  } cell_ctrl_t;

endpackage

[rtl/core/smf_if.sv]
interface smf_in_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          end_of_sequence;

  modport source (output valid, output sample, output end_of_sequence, input ready);
  modport sink   (input valid, input sample, input end_of_sequence, output ready);
endinterface

interface smf_out_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] filtered;
  logic                          last_out;

  modport source (output valid, output filtered, output last_out, input ready);
  modport sink   (input valid, input filtered, input last_out, output ready);
endinterface

interface smf_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [smf_pkg::WL_BITS-1:0]   window_length;

  modport source (output valid, output window_length, input ready);
  modport sink   (input valid, input window_length, output ready);
endinterface

[rtl/core/smf_cell.sv]
module smf_cell #(
  parameter int SAMPLE_BITS = 24,
  parameter int CNT_BITS    = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  smf_pkg::cell_ctrl_t           ctrl_i,
  input  logic                          active_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic signed [SAMPLE_BITS-1:0] probe_i,
  output logic signed [SAMPLE_BITS-1:0] sample_o,
  output logic signed [SAMPLE_BITS-1:0] probe_o,
  output logic [CNT_BITS-1:0]           lt_o,
  output logic [CNT_BITS-1:0]           le_o
);
  import smf_pkg::*;

  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic signed [SAMPLE_BITS-1:0] probe_q;
  logic [CNT_BITS-1:0]           lt_q, lt_d;
  logic [CNT_BITS-1:0]           le_q, le_d;

  // Count window samples below / not above the held sample
  always_comb begin
    lt_d = lt_q;
    le_d = le_q;
    if (ctrl_i.shift) begin
      lt_d = '0;
      le_d = '0;
    end else if (ctrl_i.rank && active_i) begin
      if (probe_q < sample_q) lt_d = lt_q + CNT_BITS'(1);
      if (probe_q <= sample_q) le_d = le_q + CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= '0;
      le_q <= '0;
    end else begin
      lt_q <= lt_d;
      le_q <= le_d;
    end
  end

  // Hold the sample; take the neighbor's sample on shift, rotate probes on rank
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      sample_q <= sample_i;
      probe_q  <= sample_i;
    end else if (ctrl_i.rank) begin
      probe_q  <= probe_i;
    end
  end

  assign sample_o = sample_q;
  assign probe_o  = probe_q;
  assign lt_o     = lt_q;
  assign le_o     = le_q;

endmodule

[rtl/core/sliding_median_filter_top.sv]
// Running median filter over a stream of signed Q16.8 samples.
// in_i   : one sample per transfer; end_of_sequence marks the last sample.
// out_o  : filtered samples in sequence order; last_out marks the final one.
// cfg_i  : window length W (1..MAX_WINDOW, 0 acts as 1, larger values clip).
//          A write drops the sequence in progress.
// Positions whose window lies wholly inside the sequence get the window
// median (mean of the two middle values for even W, floored); a zero sample
// at the center gives zero; other positions pass through unchanged.
// One sample at a time: after a transfer the chain ranks the window
// (each cell compares itself to one rotating probe per cycle), then the
// result is written into the output register, and the next sample is
// taken only once the block is back in idle. The last sample is followed
// by a flush, one step per pending position.
// A stalled receiver holds the output register and the block waits.
// Reset sets W to 5 and starts an empty sequence.
module sliding_median_filter_top #(
  parameter int MAX_WINDOW  = 15,
  parameter int SAMPLE_BITS = 24
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  smf_in_if.sink    in_i,
  smf_out_if.source out_o,
  smf_cfg_if.sink   cfg_i
);
  import smf_pkg::*;

  localparam int CW    = $clog2(MAX_WINDOW + 1);
  localparam int IW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int W_RST = (WL_RESET > MAX_WINDOW) ? MAX_WINDOW : WL_RESET;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RANK  = 2'd1;
  localparam logic [1:0] S_EMIT  = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] w_q, w_d, d_q, d_d, hl_q, hl_d;
  logic [CW-1:0] seen_q, seen_d, seen_inc;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          last_q, last_d;

  logic                          out_valid_q, out_valid_d;
  logic signed [SAMPLE_BITS-1:0] out_data_q, out_data_d;
  logic                          out_last_q, out_last_d;

  logic       cfg_fire, in_fire, slot_free;
  int         wl_eff;
  cell_ctrl_t ctrl;

  logic signed [SAMPLE_BITS-1:0] smp [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] prb [MAX_WINDOW];
  logic [CW-1:0]                 lt  [MAX_WINDOW];
  logic [CW-1:0]                 le  [MAX_WINDOW];

  logic signed [SAMPLE_BITS-1:0] med_a, med_b, median, rd_data, main_val;
  logic signed [SAMPLE_BITS:0]   med_sum;
  logic [CW-1:0]                 rd_idx, flush_idx;
  logic                          flush_emit;

  // Handshakes: configuration wins over samples
  assign cfg_i.ready = (state_q == S_IDLE);
  assign in_i.ready  = (state_q == S_IDLE) && !cfg_i.valid;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;
  assign in_fire     = in_i.valid && in_i.ready;
  assign slot_free   = !out_valid_q || out_o.ready;

  // Cell chain: samples move down, probes rotate over the first W cells
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    localparam int NXT = (i + 1) % MAX_WINDOW;
    logic signed [SAMPLE_BITS-1:0] s_in, p_in;

    if (i == 0) begin : g_head
      assign s_in = in_i.sample;
    end else begin : g_body
      assign s_in = smp[i-1];
    end
    assign p_in = (CW'(i) == w_q - CW'(1)) ? prb[0] : prb[NXT];

    smf_cell #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .CNT_BITS   (CW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .active_i(CW'(i) < w_q),
      .sample_i(s_in),
      .probe_i (p_in),
      .sample_o(smp[i]),
      .probe_o (prb[i]),
      .lt_o    (lt[i]),
      .le_o    (le[i])
    );
  end

  // Pick the cells whose rank covers the two middle positions
  always_comb begin
    med_a = '0;
    med_b = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if (lt[i] <= d_q && d_q < le[i]) med_a = med_a | smp[i];
      if (lt[i] <= hl_q && hl_q < le[i]) med_b = med_b | smp[i];
    end
    med_sum = {med_a[SAMPLE_BITS-1], med_a} + {med_b[SAMPLE_BITS-1], med_b};
    median  = med_sum[SAMPLE_BITS:1];
  end

  // Center tap in normal operation, one position earlier while flushing
  assign rd_idx     = (state_q == S_FLUSH) ? d_q - CW'(1) : d_q;
  assign rd_data    = smp[rd_idx[IW-1:0]];
  assign flush_idx  = cnt_q - CW'(1);
  assign flush_emit = flush_idx < seen_q;
  assign seen_inc   = (seen_q == CW'(MAX_WINDOW)) ? seen_q : seen_q + CW'(1);

  always_comb begin
    if (seen_q < w_q) main_val = rd_data;
    else if (rd_data == '0) main_val = '0;
    else main_val = median;
  end

  // Clip the written window length
  always_comb begin
    wl_eff = int'(cfg_i.window_length);
    if (wl_eff < 1) wl_eff = 1;
    if (wl_eff > MAX_WINDOW) wl_eff = MAX_WINDOW;
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    w_d         = w_q;
    d_d         = d_q;
    hl_d        = hl_q;
    seen_d      = seen_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    ctrl        = '0;
    out_valid_d = out_valid_q && !out_o.ready;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    case (state_q)
      S_IDLE: begin
        if (cfg_fire) begin
          w_d    = CW'(wl_eff);
          d_d    = CW'((wl_eff - 1) >> 1);
          hl_d   = CW'(wl_eff >> 1);
          seen_d = '0;
        end else if (in_fire) begin
          ctrl.shift = 1'b1;
          seen_d     = seen_inc;
          last_d     = in_i.end_of_sequence;
          if (seen_inc > d_q) begin
            state_d = S_RANK;
            cnt_d   = '0;
          end else if (in_i.end_of_sequence) begin
            state_d = S_FLUSH;
            cnt_d   = d_q;
          end
        end
      end
      S_RANK: begin
        ctrl.rank = 1'b1;
        if (cnt_q == w_q - CW'(1)) state_d = S_EMIT;
        else cnt_d = cnt_q + CW'(1);
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_data_d  = main_val;
          out_last_d  = last_q && (d_q == '0);
          if (last_q && d_q != '0) begin
            state_d = S_FLUSH;
            cnt_d   = d_q;
          end else begin
            state_d = S_IDLE;
            if (last_q) seen_d = '0;
          end
        end
      end
      S_FLUSH: begin
        // Pending positions leave oldest first; skip those never filled
        if (!flush_emit || slot_free) begin
          ctrl.shift = 1'b1;
          cnt_d      = flush_idx;
          if (flush_emit) begin
            out_valid_d = 1'b1;
            out_data_d  = rd_data;
            out_last_d  = (flush_idx == '0);
          end
          if (flush_idx == '0) begin
            state_d = S_IDLE;
            seen_d  = '0;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      w_q         <= CW'(W_RST);
      d_q         <= CW'((W_RST - 1) / 2);
      hl_q        <= CW'(W_RST / 2);
      seen_q      <= '0;
      cnt_q       <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      w_q         <= w_d;
      d_q         <= d_d;
      hl_q        <= hl_d;
      seen_q      <= seen_d;
      cnt_q       <= cnt_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.filtered = out_data_q;
  assign out_o.last_out = out_last_q;

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import smf_pkg::*;

  localparam int MAX_WIN       = 15;
  localparam int SBITS         = 24;
  localparam int SETTLE_CYCLES = 40;
  localparam int QUIET_LIMIT   = 3000;
  localparam int PHASE_ITEMS   = 23;
  localparam int NUM_PHASES    = 8;
  localparam int NUM_ROWS      = 31;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SRC, IDLE_RCV, IDLE_BOTH} idle_mode_e;
  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    logic signed [SBITS-1:0] filtered;
    logic                    last_out;
  } result_t;

  typedef struct packed {
    row_kind_e               kind;
    logic [WL_BITS-1:0]      wl;
    logic signed [SBITS-1:0] sample;
    logic                    eos;
    logic                    typed;
    logic signed [SBITS-1:0] t_filt;
    logic                    t_last;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  smf_in_if  #(.SAMPLE_BITS(SBITS)) in_if ();
  smf_out_if #(.SAMPLE_BITS(SBITS)) out_if ();
  smf_cfg_if                        cfg_if ();

  sliding_median_filter_top #(
    .MAX_WINDOW (MAX_WIN),
    .SAMPLE_BITS(SBITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor state: sample history newest first, fill count, window register
  logic signed [SBITS-1:0] hist [MAX_WIN];
  int                      hist_fill;
  logic [WL_BITS-1:0]      win_len_reg;

  result_t   filtered_due [$];
  result_t   step_outputs [$];
  stim_row_t directed_rows [NUM_ROWS];

  int errors       = 0;
  int quiet_cycles = 0;
  int src_idle_pct = 0;
  int rcv_stall_pct = 0;

  function automatic void clear_history();
    for (int i = 0; i < MAX_WIN; i++) hist[i] = '0;
    hist_fill = 0;
  endfunction

  function automatic int eff_window();
    int w;
    w = int'(win_len_reg);
    if (w < 1) w = 1;
    if (w > MAX_WIN) w = MAX_WIN;
    return w;
  endfunction

  // Compute the results caused by one accepted sample into step_outputs
  function automatic void median_predict(logic signed [SBITS-1:0] smp, logic eos);
    logic signed [SBITS-1:0] srt [MAX_WIN];
    logic signed [SBITS-1:0] centre, key, v;
    logic signed [SBITS:0]   pair_sum;
    result_t                 r;
    int                      w, lag, i, j, k;
    w   = eff_window();
    lag = w - w / 2 - 1;
    step_outputs.delete();
    for (i = MAX_WIN - 1; i > 0; i--) hist[i] = hist[i-1];
    hist[0] = smp;
    if (hist_fill < MAX_WIN) hist_fill++;

    if (hist_fill > lag) begin
      centre = hist[lag];
      if (hist_fill < w) begin
        v = centre;
      end else if (centre == 0) begin
        v = '0;
      end else begin
        for (i = 0; i < w; i++) srt[i] = hist[i];
        for (i = 1; i < w; i++) begin
          key = srt[i];
          j = i;
          while (j > 0 && srt[j-1] > key) begin
            srt[j] = srt[j-1];
            j--;
          end
          srt[j] = key;
        end
        if (w % 2 == 1) begin
          v = srt[w/2];
        end else begin
          // mean of the two middle values, floored by the arithmetic shift
          pair_sum = srt[w/2-1] + srt[w/2];
          v = pair_sum[SBITS:1];
        end
      end
      r.filtered = v;
      r.last_out = 1'b0;
      step_outputs.push_back(r);
    end

    // Flush pending positions oldest first, then start a new sequence
    if (eos) begin
      for (k = lag; k > 0; k--) begin
        if (k - 1 < hist_fill) begin
          r.filtered = hist[k-1];
          r.last_out = 1'b0;
          step_outputs.push_back(r);
        end
      end
      if (step_outputs.size() > 0) step_outputs[step_outputs.size()-1].last_out = 1'b1;
      clear_history();
    end
  endfunction

  function automatic logic signed [SBITS-1:0] rand_sample();
    int near_zero;
    near_zero = int'($urandom_range(1024)) - 512;
    case ($urandom_range(9))
      0:       return 24'sh7fffff;
      1:       return 24'sh800000;
      2:       return '0;
      3, 4, 5: return near_zero[SBITS-1:0];
      default: return SBITS'($urandom());
    endcase
  endfunction

  task automatic set_idling(idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin src_idle_pct = 0;  rcv_stall_pct = 0;  end
      IDLE_SRC:  begin src_idle_pct = 87; rcv_stall_pct = 0;  end
      IDLE_RCV:  begin src_idle_pct = 0;  rcv_stall_pct = 87; end
      default:   begin src_idle_pct = 31; rcv_stall_pct = 31; end
    endcase
  endtask

  // Drive one sample, wait for its transfer, then record what it should cause
  task automatic send_item(input logic signed [SBITS-1:0] smp, input logic eos,
                           input logic typed, input result_t typed_res);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid           <= 1'b1;
    in_if.sample          <= smp;
    in_if.end_of_sequence <= eos;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    median_predict(smp, eos);
    if (typed) begin
      filtered_due.push_back(typed_res);
    end else begin
      foreach (step_outputs[i]) filtered_due.push_back(step_outputs[i]);
    end
  endtask

  // Hold off until every result is out and the block has gone quiet
  task automatic settle_block();
    in_if.valid <= 1'b0;
    while (filtered_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_window(input logic [WL_BITS-1:0] wl);
    settle_block();
    cfg_if.valid         <= 1'b1;
    cfg_if.window_length <= wl;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    win_len_reg = wl;
    clear_history();
  endtask

  // Receiver side: stall at random per phase
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_if.ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // Compare each result transfer against the oldest expectation
  always @(posedge clk_i) begin : check_filtered
    result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (filtered_due.size() == 0) begin
        $error("unexpected result: filtered=%0d last_out=%0b",
               out_if.filtered, out_if.last_out);
        errors++;
      end else begin
        want = filtered_due.pop_front();
        if (out_if.filtered !== want.filtered) begin
          $error("filtered: expected %0d, actual %0d", want.filtered, out_if.filtered);
          errors++;
        end
        if (out_if.last_out !== want.last_out) begin
          $error("last_out: expected %0b, actual %0b", want.last_out, out_if.last_out);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    result_t            tres;
    logic [WL_BITS-1:0] wl;
    int                 ph, items_sent, len, n, w;
    logic               drop_tail;

    rst_ni                = 1'b0;
    in_if.valid          <= 1'b0;
    in_if.sample         <= '0;
    in_if.end_of_sequence <= 1'b0;
    cfg_if.valid         <= 1'b0;
    cfg_if.window_length <= WL_BITS'(WL_RESET);
    win_len_reg           = WL_BITS'(WL_RESET);
    clear_history();

    // Directed rows: reset window, extremes, zero center, window of one and
    // of zero, even window, dropped sequence on reconfiguration, short runs
    directed_rows = '{
      '{ROW_ITEM, 4'd0,  24'sh000100, 1'b1, 1'b1, 24'sh000100, 1'b1},
      '{ROW_ITEM, 4'd0,  24'sh7fffff, 1'b0, 1'b0, 24'sh0, 1'b0},
      '{ROW_ITEM, 4'd0,  24'sh800000, 1'b0, 1'b0, 24'sh0, 1'b0},
      '{ROW_ITEM, 4'd0,  24'sh000000, 1'b0, 1'b0, 24'sh0, 1'b0},
      '{ROW_ITEM, 4'd0,  24'sh000005, 1'b0, 1'b0, 24'sh0, 1'b0},
      '{ROW_ITEM, 4'd0,  24'shfffffd, 1'b0, 1'b0, 24'sh0, 1'b0},
      '{ROW_ITEM, 4'd0,  24'sh7fffff, 1'b0, 1'b0, 24'sh0, 1'b0},
      '{ROW_ITEM, 4'd0,  24'sh000100, 1'b1, 1'b0, 24'sh0, 1'b0},
      '{ROW_CFG,  4'd1,  24'sh0, 1'b0, 1'b0, 24'sh0, 1'b0},
      '{ROW_ITEM, 4'd0,  24'sh800000, 1'b0, 1'b1, 24'sh800000, 1'b0},
      '{ROW_ITEM, 4'd0,  24'sh7fffff, 1'b0, 1'b1, 24'sh7fffff, 1'b0},
      '{ROW_ITEM, 4'd0,  24'sh000000, 1'b1, 1'b1, 24'sh000000, 1'b1},
      '{ROW_CFG,  4'd0,  24'sh0, 1'b0, 1'b0, 24'sh0, 1'b0},
      '{ROW_ITEM, 4'd0,  24'sh123456, 1'b0, 1'b1, 24'sh123456, 1'b0},
      '{ROW_ITEM, 4'd0,  24'shedcba9, 1'b1, 1'b1, 24'shedcba9, 1'b1},
      '{ROW_CFG,  4'd2,  24'sh0, 1'b0, 1'b0, 24'sh0, 1'b0},
      '{ROW_ITEM, 4'd0,  24'shffffff, 1'b0, 1'b0, 24'sh0, 1'b0},
      '{ROW_ITEM, 4'd0,  24'shfffffe, 1'b0, 1'b0, 24'sh0, 1'b0},
      '{ROW_ITEM, 4'd0,  24'sh000003, 1'b0, 1'b0, 24'sh0, 1'b0},
      '{ROW_ITEM, 4'd0,  24'sh000004, 1'b0, 1'b0, 24'sh0, 1'b0},
      '{ROW_ITEM, 4'd0,  24'sh7fffff, 1'b1, 1'b0, 24'sh0, 1'b0},
      '{ROW_CFG,  4'd15, 24'sh0, 1'b0, 1'b0, 24'sh0, 1'b0},
      '{ROW_ITEM, 4'd0,  24'sh000010, 1'b0, 1'b0, 24'sh0, 1'b0},
      '{ROW_ITEM, 4'd0,  24'shfff000, 1'b0, 1'b0, 24'sh0, 1'b0},
      '{ROW_ITEM, 4'd0,  24'sh000020, 1'b0, 1'b0, 24'sh0, 1'b0},
      '{ROW_ITEM, 4'd0,  24'sh000030, 1'b0, 1'b0, 24'sh0, 1'b0},
      '{ROW_ITEM, 4'd0,  24'sh7fff00, 1'b0, 1'b0, 24'sh0, 1'b0},
      '{ROW_ITEM, 4'd0,  24'sh800100, 1'b0, 1'b0, 24'sh0, 1'b0},
      '{ROW_CFG,  4'd4,  24'sh0, 1'b0, 1'b0, 24'sh0, 1'b0},
      '{ROW_ITEM, 4'd0,  24'sh000042, 1'b0, 1'b0, 24'sh0, 1'b0},
      '{ROW_ITEM, 4'd0,  24'shffffbe, 1'b1, 1'b0, 24'sh0, 1'b0}
    };

    set_idling(IDLE_NONE);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_window(directed_rows[i].wl);
      end else begin
        tres.filtered = directed_rows[i].t_filt;
        tres.last_out = directed_rows[i].t_last;
        send_item(directed_rows[i].sample, directed_rows[i].eos,
                  directed_rows[i].typed, tres);
      end
    end

    // Random phases: new window and idling pattern each, whole sequences of
    // random length, sometimes a sequence cut off by the next write
    tres = '0;
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       wl = 4'd15;
        1:       wl = 4'd0;
        2:       wl = 4'd1;
        3:       wl = 4'd2;
        default: wl = $urandom_range(15);
      endcase
      write_window(wl);
      set_idling(idle_mode_e'(ph % 4));
      w = eff_window();
      items_sent = 0;
      while (items_sent < PHASE_ITEMS) begin
        if ($urandom_range(3) == 0) len = $urandom_range(3 * w + 2, 1);
        else                        len = $urandom_range(2 * w + 2, 1);
        // Keep the phase to its item budget
        if (len > PHASE_ITEMS - items_sent) len = PHASE_ITEMS - items_sent;
        drop_tail = (items_sent + len >= PHASE_ITEMS) && ($urandom_range(3) == 0);
        for (n = 0; n < len; n++)
          send_item(rand_sample(), (n == len - 1) && !drop_tail, 1'b0, tres);
        items_sent += len;
      end
    end

    settle_block();
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
